>>> rtl/core/compress_and_pack_coefficients_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coefficient compress-and-pack block
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPRESS_AND_PACK_COEFFICIENTS_ASSERT_SVH
`define COMPRESS_AND_PACK_COEFFICIENTS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants, reciprocal for the compressor and inter-module types.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Polynomial and quantizer settings.
  localparam int COEFF_COUNT = 512;
  localparam int QUANT_BITS  = 4;
  localparam int MODULUS     = 3329;

  // Fixed field widths.
  localparam int COEF_W = 16;
  localparam int BYTE_W = 8;
  localparam int ACC_W  = 24;
  localparam int HELD_W = 5;

  // Coefficient position counter.
  localparam int IDX_W = (COEFF_COUNT > 1) ? $clog2(COEFF_COUNT) : 1;

  // Division by the modulus as a multiply by a rounded-up reciprocal. With
  // 2^SHIFT >= dividend range * MODULUS the truncated product is exact.
  localparam int SCALED_W     = COEF_W + QUANT_BITS + 1;
  localparam int MOD_LOG      = $clog2(MODULUS);
  localparam int RECIP_SHIFT  = SCALED_W + MOD_LOG;
  localparam int RECIP_W      = SCALED_W + 2;
  localparam int PROD_W       = SCALED_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
  localparam logic [RECIP_W-1:0]  RECIP    = RECIP_W'(RECIP_FULL);
  localparam logic [SCALED_W-1:0] HALF_MOD = SCALED_W'(MODULUS / 2);

  // Request queue between compressor and packer (depth a power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One compressed coefficient on its way to the packer.
  typedef struct packed {
    logic [QUANT_BITS-1:0] value;
    logic                  last_coeff;
  } cpc_item_t;

  // Queue occupancy and traffic, for checking.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              push;
    logic              pop;
  } cpc_queue_status_t;

  // Packer state, for checking.
  typedef struct packed {
    logic [HELD_W-1:0] held;
    logic              flushing;
    logic              byte_load;
    logic              byte_last;
  } cpc_pack_status_t;

endpackage

>>> rtl/core/cpc_front.sv
// ----------------------------------------------------------------------------
// cpc_front
// Takes coefficients, compresses them and marks the last one of a polynomial.
// ----------------------------------------------------------------------------
module cpc_front
  import cpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [COEF_W-1:0] in_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output cpc_item_t         push_item
);

  logic                  stage_v_r, stage_v_nxt;
  cpc_item_t             item_r, item_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  stage_ready;
  logic                  accept;
  logic                  is_last;
  logic [SCALED_W-1:0]   scaled;
  logic [PROD_W-1:0]     product;

  // The stage frees up when empty or when the queue takes its request.
  assign stage_ready = !stage_v_r || push_ready;
  assign in_tready   = stage_ready;
  assign accept      = in_tvalid && stage_ready;
  assign is_last     = (idx_r == IDX_W'(COEFF_COUNT - 1));

  // Scale and round, then divide by the modulus through the reciprocal.
  assign scaled  = {1'b0, in_tdata, {QUANT_BITS{1'b0}}} + HALF_MOD;
  assign product = PROD_W'(scaled) * PROD_W'(RECIP);

  // Next-state logic for the position counter and the result stage.
  always_comb begin
    idx_nxt     = idx_r;
    stage_v_nxt = stage_v_r;
    item_nxt    = item_r;
    if (stage_ready) begin
      stage_v_nxt = in_tvalid;
    end
    if (accept) begin
      item_nxt.value      = product[RECIP_SHIFT +: QUANT_BITS];
      item_nxt.last_coeff = is_last;
      idx_nxt             = is_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = stage_v_r;
  assign push_item  = item_r;

endmodule

>>> rtl/core/cpc_queue.sv
// ----------------------------------------------------------------------------
// cpc_queue
// Short first-in first-out queue of compressed coefficients.
// ----------------------------------------------------------------------------
module cpc_queue
  import cpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  cpc_item_t         push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cpc_item_t         pop_item,
  output cpc_queue_status_t status
);

  cpc_item_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_item   = entry_r[rd_ptr_r];

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push_fire) - QCNT_W'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign status.count = count_r;
  assign status.push  = push_fire;
  assign status.pop   = pop_fire;

endmodule

>>> rtl/core/cpc_packer.sv
// ----------------------------------------------------------------------------
// cpc_packer
// Packs compressed values LSB-first into bytes and flushes each polynomial.
// ----------------------------------------------------------------------------
module cpc_packer
  import cpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cpc_item_t         pop_item,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic              out_tlast,
  output cpc_pack_status_t  status
);

  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_m;
  logic [HELD_W-1:0] held_r, held_nxt, held_m;
  logic              flush_r, flush_nxt, flush_m;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              out_ok;
  logic              take;
  logic              load;

  // The output register can take a byte when empty or being drained.
  assign out_ok    = !out_valid_r || out_tready;
  assign pop_ready = out_ok && !flush_r && (held_r < HELD_W'(BYTE_W));
  assign take      = pop_ready && pop_valid;

  // Merge a new value above the held bits, then emit at most one byte.
  always_comb begin
    acc_m   = acc_r;
    held_m  = held_r;
    flush_m = flush_r;
    if (take) begin
      acc_m   = acc_r | (ACC_W'(pop_item.value) << held_r[2:0]);
      held_m  = held_r + HELD_W'(QUANT_BITS);
      flush_m = pop_item.last_coeff;
    end
    acc_nxt   = acc_m;
    held_nxt  = held_m;
    flush_nxt = flush_m;
    load      = 1'b0;
    byte_nxt  = acc_m[BYTE_W-1:0];
    last_nxt  = 1'b0;
    if (out_ok) begin
      if (held_m >= HELD_W'(BYTE_W)) begin
        load     = 1'b1;
        acc_nxt  = acc_m >> BYTE_W;
        held_nxt = held_m - HELD_W'(BYTE_W);
        // When flushing, a full byte that empties the accumulator ends the polynomial.
        if (flush_m && (held_nxt == '0)) begin
          last_nxt  = 1'b1;
          flush_nxt = 1'b0;
          acc_nxt   = '0;
        end
      end else if (flush_m) begin
        // Leftover bits go out zero-filled as the final byte.
        load      = 1'b1;
        last_nxt  = 1'b1;
        acc_nxt   = '0;
        held_nxt  = '0;
        flush_nxt = 1'b0;
      end
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      held_r      <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      held_r      <= held_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  assign status.held      = held_r;
  assign status.flushing  = flush_r;
  assign status.byte_load = load;
  assign status.byte_last = last_nxt;

endmodule

>>> rtl/core/compress_and_pack_coefficients.sv
// ----------------------------------------------------------------------------
// compress_and_pack_coefficients
// Compresses polynomial coefficients and packs them LSB-first into bytes.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_       slave      in_tvalid/in_tready  in_tdata[15:0] coefficient
//   out_      master     out_tvalid/out_tready out_tdata[7:0] byte, out_tlast
//
// One coefficient is accepted per cycle while the queue is not full.
// The compressor stage, the queue and the packer each add one register, and
// the coefficient that completes a byte passes all three before it is offered.
// The packer emits one byte per cycle while out_tready is high, so at up to
// eight bits per coefficient it keeps up; leftover bits at a polynomial end go out zero-filled.
// A four-entry queue lets the compressor keep accepting while output stalls.
// Synchronous active-low reset clears all counters and the bit accumulator.
// ----------------------------------------------------------------------------
module compress_and_pack_coefficients
  import cpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [COEF_W-1:0] in_tdata,   // [15:0] coefficient
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic              out_tlast
);

  logic              front_valid;
  logic              queue_ready;
  cpc_item_t         front_item;
  logic              pack_valid;
  logic              pack_ready;
  cpc_item_t         pack_item;
  cpc_queue_status_t q_st;
  cpc_pack_status_t  pk_st;

  // Compressor front end.
  cpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_item  (front_item)
  );

  // Queue between compressor and packer.
  cpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_item  (front_item),
    .pop_valid  (pack_valid),
    .pop_ready  (pack_ready),
    .pop_item   (pack_item),
    .status     (q_st)
  );

  // Bit packer and output register.
  cpc_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pack_valid),
    .pop_ready  (pack_ready),
    .pop_item   (pack_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .status     (pk_st)
  );

  // Checks on the cooperation of the three parts.
`include "compress_and_pack_coefficients_assert.svh"

  `CPC_ASSERT_SAME(a_front_holds, front_valid && !queue_ready, !in_tready, "front took a coefficient while blocked")
  `CPC_ASSERT_NEXT(a_queue_grows, q_st.push && !q_st.pop, q_st.count == $past(q_st.count) + QCNT_W'(1), "queue count lost a request")
  `CPC_ASSERT_NEXT(a_last_clears, pk_st.byte_load && pk_st.byte_last, (pk_st.held == '0) && !pk_st.flushing, "packer kept bits past the last byte")

endmodule
